// ----- rtl/core/idm_pkg.sv -----
// idm_pkg: shared widths and payload types for the invariant divisor block
// no dependencies; used by the channel interfaces and the top level
package idm_pkg;

   // fixed width of every payload field and of the divisor write data
   localparam int unsigned FIELD_WIDTH = 32;

   // default working width of the arithmetic
   localparam int unsigned DATA_WIDTH_DEFAULT = 32;

   typedef logic [FIELD_WIDTH-1:0] field_type;

endpackage

// ----- rtl/core/idm_req_if.sv -----
// idm_req_if: valid/ready channel that carries one dividend word
// depends on idm_pkg
interface idm_req_if;

   logic                valid;
   logic                ready;
   idm_pkg::field_type  dividend;

   modport source (output valid, output dividend, input ready);
   modport sink   (input valid, input dividend, output ready);

endinterface

// ----- rtl/core/idm_rsp_if.sv -----
// idm_rsp_if: valid/ready channel that carries one quotient/remainder word
// depends on idm_pkg
interface idm_rsp_if;

   logic                valid;
   logic                ready;
   idm_pkg::field_type  quotient;
   idm_pkg::field_type  remainder;

   modport source (output valid, output quotient, output remainder, input ready);
   modport sink   (input valid, input quotient, input remainder, output ready);

endinterface

// ----- rtl/core/invariant_divisor_div_mod.sv -----
// invariant_divisor_div_mod: unsigned divide and modulo by a configured divisor
// depends on idm_pkg, idm_req_if and idm_rsp_if
//
//   channel   direction   handshake          payload
//   req_ch    in          valid / ready      dividend
//   rsp_ch    out         valid / ready      quotient, remainder
//   csr       in          csr_we, no wait    csr_wdata (divisor)
//
// one word per cycle sustained while rsp_ch is ready and the sequencer is idle; a word
// passes in order through input register, magic multiply, add and shift, back multiply, remainder
// the two DATA_WIDTH x DATA_WIDTH multipliers set the stage depth
// a divisor write starts the magic sequencer: log scan, long division at one quotient
// bit per cycle and a finish step; req_ch.ready stays low meanwhile. reset loads the
// constants for divisor one
// each stage moves on when it is empty or the next one moves, so a stall on rsp_ch
// only fills bubbles and never drops or repeats a word
module invariant_divisor_div_mod #(
   parameter int unsigned DATA_WIDTH = idm_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  idm_pkg::field_type csr_wdata,
   idm_req_if.sink            req_ch,
   idm_rsp_if.source          rsp_ch
);

   localparam int unsigned SW = $clog2(DATA_WIDTH);
   localparam int unsigned PW = 2 * DATA_WIDTH;
   localparam logic [SW-1:0] LAST_STEP = SW'(DATA_WIDTH - 1);
   localparam int unsigned NUM_STAGES = 5;

   // magic sequencer states
   localparam logic [1:0] CFG_IDLE = 2'd0;
   localparam logic [1:0] CFG_LOG  = 2'd1;
   localparam logic [1:0] CFG_DIV  = 2'd2;
   localparam logic [1:0] CFG_FIN  = 2'd3;

   // ---------------------------------------------------------------------------
   // magic constant sequencer
   // ---------------------------------------------------------------------------
   logic [1:0]            cfg_state_ff, cfg_state_in;
   logic [DATA_WIDTH-1:0] divisor_ff, divisor_in;
   logic [DATA_WIDTH-1:0] scan_ff, scan_in;     // divisor shifted down to find log2
   logic [SW-1:0]         log_ff, log_in;       // floor log2 of the divisor
   logic [SW-1:0]         step_ff, step_in;     // quotient bit counter
   logic [DATA_WIDTH-1:0] part_ff, part_in;     // partial remainder of 2^(l+W) / d
   logic [DATA_WIDTH-1:0] quot_ff, quot_in;     // quotient bits collected so far
   logic [DATA_WIDTH-1:0] mul_ff, mul_in;
   logic [DATA_WIDTH-1:0] add_ff, add_in;
   logic [SW-1:0]         shift_ff, shift_in;
   logic                  zero_ff, zero_in;     // divisor zero
   logic                  pow2_ff, pow2_in;     // divisor a power of two
   logic [DATA_WIDTH-1:0] mask_ff, mask_in;     // divisor - 1 for the masked remainder

   logic [DATA_WIDTH:0]   twice;
   logic [DATA_WIDTH:0]   diff;
   logic                  sub_ok;
   logic [DATA_WIDTH-1:0] err;
   logic                  is_pow2;
   logic                  round_up;

   always_comb begin
      twice    = {part_ff, 1'b0};
      diff     = twice - {1'b0, divisor_ff};
      sub_ok   = twice >= {1'b0, divisor_ff};
      err      = divisor_ff - part_ff;
      is_pow2  = (divisor_ff & (divisor_ff - DATA_WIDTH'(1))) == '0;
      round_up = err < (DATA_WIDTH'(1) << log_ff);
   end

   always_comb begin
      cfg_state_in = cfg_state_ff;
      divisor_in   = divisor_ff;
      scan_in      = scan_ff;
      log_in       = log_ff;
      step_in      = step_ff;
      part_in      = part_ff;
      quot_in      = quot_ff;
      mul_in       = mul_ff;
      add_in       = add_ff;
      shift_in     = shift_ff;
      zero_in      = zero_ff;
      pow2_in      = pow2_ff;
      mask_in      = mask_ff;

      unique case (cfg_state_ff)
         CFG_IDLE: begin
         end
         CFG_LOG: begin
            if (|scan_ff[DATA_WIDTH-1:1]) begin
               scan_in = scan_ff >> 1;
               log_in  = log_ff + SW'(1);
            end else begin
               // start the long division with 2^l already brought down
               cfg_state_in = CFG_DIV;
               part_in      = DATA_WIDTH'(1) << log_ff;
               quot_in      = '0;
               step_in      = '0;
            end
         end
         CFG_DIV: begin
            part_in = sub_ok ? diff[DATA_WIDTH-1:0] : twice[DATA_WIDTH-1:0];
            quot_in = {quot_ff[DATA_WIDTH-2:0], sub_ok};
            step_in = step_ff + SW'(1);
            if (step_ff == LAST_STEP) begin
               cfg_state_in = CFG_FIN;
            end
         end
         CFG_FIN: begin
            cfg_state_in = CFG_IDLE;
            zero_in      = divisor_ff == '0;
            pow2_in      = is_pow2;
            mask_in      = divisor_ff - DATA_WIDTH'(1);
            priority if (divisor_ff == '0) begin
               mul_in   = '0;
               add_in   = '0;
               shift_in = '0;
            end else if (!is_pow2) begin
               // round up when the error is small enough, else add the multiplier
               mul_in   = quot_ff + DATA_WIDTH'(round_up);
               add_in   = round_up ? '0 : quot_ff;
               shift_in = log_ff;
            end else if (divisor_ff == DATA_WIDTH'(1)) begin
               mul_in   = '1;
               add_in   = '1;
               shift_in = '0;
            end else begin
               mul_in   = {1'b1, (DATA_WIDTH-1)'(0)};
               add_in   = '0;
               shift_in = log_ff - SW'(1);
            end
         end
         default: begin
            cfg_state_in = CFG_IDLE;
         end
      endcase

      if (csr_we) begin
         cfg_state_in = CFG_LOG;
         divisor_in   = csr_wdata[DATA_WIDTH-1:0];
         scan_in      = csr_wdata[DATA_WIDTH-1:0];
         log_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_state_ff <= CFG_IDLE;
         divisor_ff   <= DATA_WIDTH'(1);
         mul_ff       <= '1;
         add_ff       <= '1;
         shift_ff     <= '0;
         zero_ff      <= 1'b0;
         pow2_ff      <= 1'b1;
         mask_ff      <= '0;
         step_ff      <= '0;
      end else begin
         cfg_state_ff <= cfg_state_in;
         divisor_ff   <= divisor_in;
         mul_ff       <= mul_in;
         add_ff       <= add_in;
         shift_ff     <= shift_in;
         zero_ff      <= zero_in;
         pow2_ff      <= pow2_in;
         mask_ff      <= mask_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      log_ff  <= log_in;
      part_ff <= part_in;
      quot_ff <= quot_in;
   end

   // ---------------------------------------------------------------------------
   // datapath pipeline
   // ---------------------------------------------------------------------------
   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic [NUM_STAGES:0]   adv;   // stage k loads a new word when adv[k]

   always_comb begin
      adv[NUM_STAGES] = rsp_ch.ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_ch.ready = adv[0] && (cfg_state_ff == CFG_IDLE);

   always_comb begin
      vld_in[0] = adv[0] ? (req_ch.valid && req_ch.ready) : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 0: input word
   logic [DATA_WIDTH-1:0] s0_v_ff, s0_v_in;
   // stage 1: magic product
   logic [DATA_WIDTH-1:0] s1_v_ff, s1_v_in;
   logic [PW-1:0]         s1_prod_ff, s1_prod_in;
   // stage 2: add, take the high half, post shift
   logic [DATA_WIDTH-1:0] s2_v_ff, s2_v_in;
   logic [DATA_WIDTH-1:0] s2_q_ff, s2_q_in;
   logic [PW-1:0]         s2_sum;
   // stage 3: quotient times divisor
   logic [DATA_WIDTH-1:0] s3_v_ff, s3_v_in;
   logic [DATA_WIDTH-1:0] s3_q_ff, s3_q_in;
   logic [DATA_WIDTH-1:0] s3_qd_ff, s3_qd_in;
   // stage 4: output register
   logic [DATA_WIDTH-1:0] s4_q_ff, s4_q_in;
   logic [DATA_WIDTH-1:0] s4_r_ff, s4_r_in;

   always_comb begin
      s0_v_in    = req_ch.dividend[DATA_WIDTH-1:0];

      s1_v_in    = s0_v_ff;
      s1_prod_in = PW'(s0_v_ff) * PW'(mul_ff);

      s2_v_in    = s1_v_ff;
      s2_sum     = s1_prod_ff + PW'(add_ff);
      s2_q_in    = zero_ff ? '1 : (s2_sum[PW-1:DATA_WIDTH] >> shift_ff);

      s3_v_in    = s2_v_ff;
      s3_q_in    = s2_q_ff;
      s3_qd_in   = s2_q_ff * divisor_ff;   // low half only

      s4_q_in    = s3_q_ff;
      priority if (zero_ff) begin
         s4_r_in = s3_v_ff;
      end else if (pow2_ff) begin
         s4_r_in = s3_v_ff & mask_ff;
      end else begin
         s4_r_in = s3_v_ff - s3_qd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s0_v_ff <= s0_v_in;
      end
      if (adv[1]) begin
         s1_v_ff    <= s1_v_in;
         s1_prod_ff <= s1_prod_in;
      end
      if (adv[2]) begin
         s2_v_ff <= s2_v_in;
         s2_q_ff <= s2_q_in;
      end
      if (adv[3]) begin
         s3_v_ff  <= s3_v_in;
         s3_q_ff  <= s3_q_in;
         s3_qd_ff <= s3_qd_in;
      end
      if (adv[4]) begin
         s4_q_ff <= s4_q_in;
         s4_r_ff <= s4_r_in;
      end
   end

   assign rsp_ch.valid     = vld_ff[NUM_STAGES-1];
   assign rsp_ch.quotient  = idm_pkg::FIELD_WIDTH'(s4_q_ff);
   assign rsp_ch.remainder = idm_pkg::FIELD_WIDTH'(s4_r_ff);

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------
   a_busy_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (cfg_state_ff != CFG_IDLE) |-> !req_ch.ready)
      else $error("word taken while magic constants were being derived");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> vld_ff[0])
      else $error("accepted word did not enter the input stage");

   a_write_starts_seq: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (cfg_state_ff == CFG_LOG))
      else $error("divisor write did not start the sequencer");

   a_zero_magic: assert property (@(posedge clock) disable iff (reset)
      (zero_ff && cfg_state_ff == CFG_IDLE) |-> (mul_ff == '0 && add_ff == '0))
      else $error("zero divisor left nonzero magic constants");

endmodule

// ----- tb/sv/invariant_divisor_div_mod_tb.sv -----
`timescale 1ns / 1ps
// invariant_divisor_div_mod_tb: self-checking bench for divide and modulo by a programmed divisor
// depends on idm_pkg, idm_req_if, idm_rsp_if and invariant_divisor_div_mod
module invariant_divisor_div_mod_tb;

   // watchdog, far above the slowest legal run of about 1250 words
   localparam int unsigned CYCLE_LIMIT   = 300000;
   // each side goes quiet in about this many cycles of a hundred
   localparam int unsigned IDLE_PERCENT  = 17;
   // covers the magic sequencer worst case plus the five-stage pipe, with margin
   localparam int unsigned SETTLE_CYCLES = 80;
   // drain time at the end
   localparam int unsigned DRAIN_CYCLES  = 20;
   localparam int unsigned REPORT_LIMIT  = 10;
   // long receiver hold-off, well past the pipe depth so the input side backs up
   localparam int unsigned HOLD_CYCLES   = 300;

   typedef idm_pkg::field_type word_type;

   // one predicted division, with its operands kept for reporting
   typedef struct {
      word_type dividend;
      word_type divisor;
      word_type quotient;
      word_type remainder;
   } division_type;

   logic     clock     = 1'b0;
   logic     reset     = 1'b1;
   logic     csr_we    = 1'b0;
   word_type csr_wdata = '0;

   idm_req_if req_ch ();
   idm_rsp_if rsp_ch ();

   invariant_divisor_div_mod dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   // predictor copy of the divisor and the constants derived from it
   word_type     divisor_now;
   word_type     magic_mul;
   word_type     magic_add;
   logic [4:0]   magic_shift;

   // divisions in flight, oldest first
   division_type pending_divisions[$];
   division_type oldest;

   int unsigned fault_count   = 0;
   int unsigned cycle_count   = 0;
   // both sides stop idling while this is set
   logic        steady_flow   = 1'b0;
   // cycles left in a forced receiver hold-off
   int unsigned rsp_hold_left = 0;

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // derive multiplier, addend and post shift for a new divisor
   function automatic void load_divisor(input word_type d);
      int unsigned lg;
      logic [63:0] big;
      logic [63:0] mul;
      logic [63:0] rest;
      divisor_now = d;
      if (d == '0) begin
         // zero divisor: constants cleared, answers come from the special path
         magic_mul   = '0;
         magic_add   = '0;
         magic_shift = '0;
         return;
      end
      lg = 0;
      for (int b = 1; b < 32; b++)
         if (d[b])
            lg = b;
      if ((d & (d - 1)) != '0) begin
         // general case: 2^(l+32)/d, rounded up when the error is small enough
         big  = 64'd1 << (lg + 32);
         mul  = big / {32'd0, d};
         rest = big - mul * {32'd0, d};
         if ({32'd0, d} - rest < (64'd1 << lg)) begin
            mul       = mul + 64'd1;
            magic_add = '0;
         end else begin
            magic_add = mul[31:0];
         end
         magic_mul   = mul[31:0];
         magic_shift = lg[4:0];
      end else if (d == 32'd1) begin
         // divide by one: (v+1)(2^32-1) >> 32 gives v back
         magic_mul   = '1;
         magic_add   = '1;
         magic_shift = '0;
      end else begin
         // other powers of two: half-scale multiplier, one less shift
         magic_mul   = 32'h8000_0000;
         magic_add   = '0;
         magic_shift = lg[4:0] - 5'd1;
      end
   endfunction

   // expected quotient and remainder for one dividend under the current divisor
   function automatic division_type divide_word(input word_type v);
      division_type a;
      logic [63:0]  prod;
      a.dividend = v;
      a.divisor  = divisor_now;
      if (divisor_now == '0) begin
         // zero divisor: quotient all ones, dividend passes through as remainder
         a.quotient  = '1;
         a.remainder = v;
      end else begin
         prod       = {32'd0, v} * {32'd0, magic_mul} + {32'd0, magic_add};
         a.quotient = prod[63:32] >> magic_shift;
         if ((divisor_now & (divisor_now - 1)) == '0)
            // power of two: remainder is the low bits below the divisor
            a.remainder = v & (divisor_now - 1);
         else
            a.remainder = v - a.quotient * divisor_now;
      end
      return a;
   endfunction

   task automatic report_fault(input string msg);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display("error at cycle %0d: %s", cycle_count, msg);
   endtask

   // offer one dividend, idling at random first; valid stays high on return
   task automatic send_dividend(input word_type v);
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.dividend <= v;
      @(posedge clock);
      while (req_ch.ready !== 1'b1)
         @(posedge clock);
      pending_divisions.push_back(divide_word(v));
   endtask

   // write the divisor once the pipe and the sequencer are quiet
   task automatic program_divisor(input word_type d);
      req_ch.valid <= 1'b0;
      while (pending_divisions.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= d;
      @(posedge clock);
      csr_we    <= 1'b0;
      load_divisor(d);
   endtask

   // divisor mix: full range, powers of two and their neighbors, small, extremes
   function automatic word_type pick_divisor();
      int unsigned k;
      k = $urandom_range(31, 1);
      case ($urandom_range(7))
         0: return $urandom();
         1: return 32'd1 << $urandom_range(31);
         2: return $urandom_range(64, 2);
         3: return (32'd1 << k) + 32'd1;
         4: return (32'd1 << k) - 32'd1;
         5: return $urandom_range(1) ? '1 : '0;
         6: return $urandom() >> $urandom_range(31);
         default: return $urandom() | 32'h8000_0000;
      endcase
   endfunction

   // dividend mix: full range, small, near a multiple of the divisor, near the top
   function automatic word_type pick_dividend();
      word_type k;
      case ($urandom_range(5))
         0, 1: return $urandom();
         2: return $urandom_range(255);
         3: begin
            // divisor one has every value as a multiple
            if (divisor_now <= 32'd1)
               return $urandom();
            k = $urandom() % ((32'hffff_ffff / divisor_now) + 32'd1);
            return k * divisor_now + ($urandom_range(1) ? '0 : divisor_now - 32'd1);
         end
         4: return 32'hffff_ffff - $urandom_range(15);
         default: return $urandom() >> $urandom_range(31);
      endcase
   endfunction

   // reset constants are those of divisor one
   task automatic test_reset_divisor();
      send_dividend(32'd0);
      send_dividend(32'd1);
      send_dividend(32'h8000_0000);
      send_dividend(32'hffff_ffff);
   endtask

   // zero, largest, top power of two, smallest power of two above one, small odd divisor
   task automatic test_divisor_extremes();
      word_type picks[5];
      picks = '{32'd0, 32'hffff_ffff, 32'h8000_0000, 32'd2, 32'd7};
      foreach (picks[i]) begin
         program_divisor(picks[i]);
         send_dividend(32'd0);
         send_dividend(32'hffff_ffff);
         send_dividend(picks[i]);
         send_dividend(picks[i] - 32'd1);
      end
   endtask

   task automatic test_random_divisors();
      repeat (14) begin
         program_divisor(pick_divisor());
         repeat (70) send_dividend(pick_dividend());
      end
   endtask

   // receiver holds off long enough for the pipe to fill and stall the input
   task automatic test_back_pressure();
      program_divisor(pick_divisor());
      rsp_hold_left <= HOLD_CYCLES;
      repeat (100) send_dividend(pick_dividend());
   endtask

   // back-to-back words with no idling on either side
   task automatic test_steady_stream();
      program_divisor(pick_divisor());
      steady_flow <= 1'b1;
      repeat (150) send_dividend(pick_dividend());
      steady_flow <= 1'b0;
   endtask

   // receiver: forced hold-off first, otherwise random idling
   always @(posedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_ch.ready  <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_ch.ready  <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // each accepted word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_divisions.size() == 0) begin
            report_fault($sformatf("word with nothing pending: q=%h r=%h",
                                   rsp_ch.quotient, rsp_ch.remainder));
         end else begin
            oldest = pending_divisions.pop_front();
            if (rsp_ch.quotient !== oldest.quotient)
               report_fault($sformatf("%h / %h quotient: expected %h, got %h",
                                      oldest.dividend, oldest.divisor,
                                      oldest.quotient, rsp_ch.quotient));
            if (rsp_ch.remainder !== oldest.remainder)
               report_fault($sformatf("%h / %h remainder: expected %h, got %h",
                                      oldest.dividend, oldest.divisor,
                                      oldest.remainder, rsp_ch.remainder));
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      req_ch.valid    = 1'b0;
      req_ch.dividend = '0;
      rsp_ch.ready    = 1'b0;
      load_divisor(32'd1);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_divisor();
      test_divisor_extremes();
      test_random_divisors();
      test_back_pressure();
      test_steady_stream();
      req_ch.valid <= 1'b0;

      // drain, then leave room for any stray extra word
      while (pending_divisions.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
